// File: design/in_order_delivery_reorder_defines.svh
// ----------------------------------------------------------------------------
// In-order delivery reorder: assertion macros
// Shared property forms for the checks at the end of the control module.
// ----------------------------------------------------------------------------
`ifndef IN_ORDER_DELIVERY_REORDER_DEFINES_SVH
`define IN_ORDER_DELIVERY_REORDER_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define IODR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define IODR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/iodr_pkg.sv
// ----------------------------------------------------------------------------
// In-order delivery reorder: package
// Sizes, status codes, cell operations and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iodr_pkg;

    localparam int HOLD_DEPTH   = 16;
    localparam int PAYLOAD_BITS = 64;
    localparam int SEQ_BITS     = 32;
    localparam int MSG_BITS     = 64;
    localparam int COUNT_BITS   = $clog2(HOLD_DEPTH + 1);

    localparam logic [1:0] ST_DELIVERED = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_REFUSED   = 2'd2;
    localparam logic [1:0] ST_BUFFERED  = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DRAIN
    } state_t;

    typedef struct packed {
        logic                      any_match;
        logic [SEQ_BITS-1:0]       head_seq;
        logic [PAYLOAD_BITS-1:0]   head_payload;
        logic [SEQ_BITS-1:0]       next_seq;
    } store_sts_t;

endpackage

`default_nettype wire

// File: design/in_order_delivery_reorder.sv
// ----------------------------------------------------------------------------
// In-order delivery reorder
// Receiver side of a sequenced stream: delivers messages in sequence order,
// holding early arrivals in a sorted row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   An item (msg_seq, msg_payload) is taken at a clock edge with start high
//   and busy low. Results appear on status, out_seq, out_payload and last for
//   one cycle each, marked by out_valid; the receiver cannot stall them.
//   Every item yields one result unless it is the next expected sequence and
//   the held head continues the run, in which case each held follower adds one
//   more result, one per cycle. last marks the final result of an item.
//   Flow: the accept edge registers the item and enters S_EVAL, which
//   registers the first result; a new item is taken only once the block is
//   idle again, after its last result is registered. All held entries are
//   compared with the item at once, one comparator per cell; the run
//   drains one cell shift per cycle.
//   The user must write the null sequence register via cfg_valid/cfg_ready/
//   cfg_data (ready is always high) only while the block is idle; not enforced.
//   Reset (rst_n low, asynchronous) empties the store, clears the last
//   delivered sequence and the null sequence, and leaves the block idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module in_order_delivery_reorder
(
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire [iodr_pkg::SEQ_BITS-1:0]         msg_seq,
    input  wire [iodr_pkg::MSG_BITS-1:0]         msg_payload,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [iodr_pkg::SEQ_BITS-1:0]         cfg_data,
    output logic                                 out_valid,
    output logic [1:0]                           status,
    output logic [iodr_pkg::SEQ_BITS-1:0]        out_seq,
    output logic [iodr_pkg::MSG_BITS-1:0]        out_payload,
    output logic                                 last
);

    iodr_pkg::store_sts_t                  sts;
    iodr_pkg::cell_op_t                    op;
    logic [iodr_pkg::HOLD_DEPTH-1:0]       occupied;
    logic [iodr_pkg::SEQ_BITS-1:0]         item_seq;
    logic [iodr_pkg::PAYLOAD_BITS-1:0]     item_payload;
    logic [iodr_pkg::HOLD_DEPTH-1:0]       lower;
    logic [iodr_pkg::HOLD_DEPTH-1:0]       match;
    logic [iodr_pkg::SEQ_BITS-1:0]         cell_seq [iodr_pkg::HOLD_DEPTH];
    logic [iodr_pkg::PAYLOAD_BITS-1:0]     cell_payload [iodr_pkg::HOLD_DEPTH];
    logic [iodr_pkg::SEQ_BITS-1:0]         second_seq;

    iodr_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .msg_seq      (msg_seq),
        .msg_payload  (msg_payload),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .sts          (sts),
        .op           (op),
        .occupied     (occupied),
        .item_seq     (item_seq),
        .item_payload (item_payload),
        .out_valid    (out_valid),
        .status       (status),
        .out_seq      (out_seq),
        .out_payload  (out_payload),
        .last         (last)
    );

    for (genvar i = 0; i < iodr_pkg::HOLD_DEPTH; i++)
    begin : g_cell
        logic                              left_lower;
        logic [iodr_pkg::SEQ_BITS-1:0]     left_seq;
        logic [iodr_pkg::PAYLOAD_BITS-1:0] left_payload;
        logic [iodr_pkg::SEQ_BITS-1:0]     right_seq;
        logic [iodr_pkg::PAYLOAD_BITS-1:0] right_payload;

        if (i == 0)
        begin : g_first
            assign left_lower   = 1'b1;
            assign left_seq     = item_seq;
            assign left_payload = item_payload;
        end
        else
        begin : g_inner
            assign left_lower   = lower[i-1];
            assign left_seq     = cell_seq[i-1];
            assign left_payload = cell_payload[i-1];
        end

        if (i == iodr_pkg::HOLD_DEPTH - 1)
        begin : g_end
            assign right_seq     = cell_seq[i];
            assign right_payload = cell_payload[i];
        end
        else
        begin : g_mid
            assign right_seq     = cell_seq[i+1];
            assign right_payload = cell_payload[i+1];
        end

        iodr_cell u_cell
        (
            .clk           (clk),
            .op            (op),
            .occupied      (occupied[i]),
            .item_seq      (item_seq),
            .item_payload  (item_payload),
            .left_lower    (left_lower),
            .left_seq      (left_seq),
            .left_payload  (left_payload),
            .right_seq     (right_seq),
            .right_payload (right_payload),
            .lower         (lower[i]),
            .match         (match[i]),
            .seq           (cell_seq[i]),
            .payload       (cell_payload[i])
        );
    end

    if (iodr_pkg::HOLD_DEPTH > 1)
    begin : g_second
        assign second_seq = cell_seq[1];
    end
    else
    begin : g_no_second
        assign second_seq = '0;
    end

    assign sts.any_match    = |match;
    assign sts.head_seq     = cell_seq[0];
    assign sts.head_payload = cell_payload[0];
    assign sts.next_seq     = second_seq;

endmodule

`default_nettype wire

// File: design/iodr_cell.sv
// ----------------------------------------------------------------------------
// In-order delivery reorder: store cell
// One slot of the sorted store. Compares its entry against the item, and
// keeps, takes the item, takes the left neighbour (shift up) or takes the
// right neighbour (pop) as the control commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iodr_cell
(
    input  wire                                  clk,
    input  wire iodr_pkg::cell_op_t              op,
    input  wire                                  occupied,
    input  wire [iodr_pkg::SEQ_BITS-1:0]         item_seq,
    input  wire [iodr_pkg::PAYLOAD_BITS-1:0]     item_payload,
    input  wire                                  left_lower,
    input  wire [iodr_pkg::SEQ_BITS-1:0]         left_seq,
    input  wire [iodr_pkg::PAYLOAD_BITS-1:0]     left_payload,
    input  wire [iodr_pkg::SEQ_BITS-1:0]         right_seq,
    input  wire [iodr_pkg::PAYLOAD_BITS-1:0]     right_payload,
    output logic                                 lower,
    output logic                                 match,
    output logic [iodr_pkg::SEQ_BITS-1:0]        seq,
    output logic [iodr_pkg::PAYLOAD_BITS-1:0]    payload
);

    logic [iodr_pkg::SEQ_BITS-1:0]     seq_reg;
    logic [iodr_pkg::SEQ_BITS-1:0]     seq_next;
    logic [iodr_pkg::PAYLOAD_BITS-1:0] payload_reg;
    logic [iodr_pkg::PAYLOAD_BITS-1:0] payload_next;

    assign lower   = occupied && (seq_reg < item_seq);
    assign match   = occupied && (seq_reg == item_seq);
    assign seq     = seq_reg;
    assign payload = payload_reg;

    always_comb
    begin
        seq_next     = seq_reg;
        payload_next = payload_reg;
        case (op)
            iodr_pkg::OP_INSERT:
            begin
                // keep smaller entries, land the item in the gap, shift the rest up
                if (!lower)
                begin
                    if (left_lower)
                    begin
                        seq_next     = item_seq;
                        payload_next = item_payload;
                    end
                    else
                    begin
                        seq_next     = left_seq;
                        payload_next = left_payload;
                    end
                end
            end
            iodr_pkg::OP_POP:
            begin
                seq_next     = right_seq;
                payload_next = right_payload;
            end
            default:
            begin
                seq_next     = seq_reg;
                payload_next = payload_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        seq_reg     <= seq_next;
        payload_reg <= payload_next;
    end

endmodule

`default_nettype wire

// File: design/iodr_ctrl.sv
// ----------------------------------------------------------------------------
// In-order delivery reorder: control
// Item capture, classification, delivery run sequencing, fill count,
// configuration register and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "in_order_delivery_reorder_defines.svh"

module iodr_ctrl
(
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire [iodr_pkg::SEQ_BITS-1:0]         msg_seq,
    input  wire [iodr_pkg::MSG_BITS-1:0]         msg_payload,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [iodr_pkg::SEQ_BITS-1:0]         cfg_data,
    input  wire iodr_pkg::store_sts_t            sts,
    output iodr_pkg::cell_op_t                   op,
    output logic [iodr_pkg::HOLD_DEPTH-1:0]      occupied,
    output logic [iodr_pkg::SEQ_BITS-1:0]        item_seq,
    output logic [iodr_pkg::PAYLOAD_BITS-1:0]    item_payload,
    output logic                                 out_valid,
    output logic [1:0]                           status,
    output logic [iodr_pkg::SEQ_BITS-1:0]        out_seq,
    output logic [iodr_pkg::MSG_BITS-1:0]        out_payload,
    output logic                                 last
);

    iodr_pkg::state_t                    state_reg;
    iodr_pkg::state_t                    state_next;
    logic [iodr_pkg::SEQ_BITS-1:0]       null_reg;
    logic [iodr_pkg::SEQ_BITS-1:0]       delivered_reg;
    logic [iodr_pkg::SEQ_BITS-1:0]       delivered_next;
    logic [iodr_pkg::COUNT_BITS-1:0]     count_reg;
    logic [iodr_pkg::COUNT_BITS-1:0]     count_next;
    logic [iodr_pkg::SEQ_BITS-1:0]       item_seq_reg;
    logic [iodr_pkg::SEQ_BITS-1:0]       item_seq_next;
    logic [iodr_pkg::PAYLOAD_BITS-1:0]   item_payload_reg;
    logic [iodr_pkg::PAYLOAD_BITS-1:0]   item_payload_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [1:0]                          status_reg;
    logic [1:0]                          status_next;
    logic [iodr_pkg::SEQ_BITS-1:0]       out_seq_reg;
    logic [iodr_pkg::SEQ_BITS-1:0]       out_seq_next;
    logic [iodr_pkg::MSG_BITS-1:0]       out_payload_reg;
    logic [iodr_pkg::MSG_BITS-1:0]       out_payload_next;
    logic                                last_reg;
    logic                                last_next;

    logic                                stale;
    logic                                in_order;
    logic                                head_follows;
    logic                                next_follows;
    logic                                full;
    logic [iodr_pkg::SEQ_BITS-1:0]       item_succ;
    logic [iodr_pkg::SEQ_BITS-1:0]       head_succ;

    assign busy         = (state_reg != iodr_pkg::S_IDLE);
    assign cfg_ready    = 1'b1;
    assign item_seq     = item_seq_reg;
    assign item_payload = item_payload_reg;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_seq      = out_seq_reg;
    assign out_payload  = out_payload_reg;
    assign last         = last_reg;

    always_comb
    begin
        for (int i = 0; i < iodr_pkg::HOLD_DEPTH; i++)
        begin
            occupied[i] = (count_reg > iodr_pkg::COUNT_BITS'(i));
        end
    end

    assign item_succ    = item_seq_reg + iodr_pkg::SEQ_BITS'(1);
    assign head_succ    = sts.head_seq + iodr_pkg::SEQ_BITS'(1);
    assign stale        = (item_seq_reg == null_reg) || (item_seq_reg <= delivered_reg);
    assign in_order     = (item_seq_reg == (delivered_reg + iodr_pkg::SEQ_BITS'(1)));
    assign head_follows = (count_reg != '0) && (sts.head_seq == item_succ);
    assign next_follows = (count_reg > iodr_pkg::COUNT_BITS'(1)) && (sts.next_seq == head_succ);
    assign full         = (count_reg == iodr_pkg::COUNT_BITS'(iodr_pkg::HOLD_DEPTH));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iodr_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = iodr_pkg::S_EVAL;
                end
            end
            iodr_pkg::S_EVAL:
            begin
                if (!stale && in_order && head_follows)
                begin
                    state_next = iodr_pkg::S_DRAIN;
                end
                else
                begin
                    state_next = iodr_pkg::S_IDLE;
                end
            end
            iodr_pkg::S_DRAIN:
            begin
                if (!next_follows)
                begin
                    state_next = iodr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = iodr_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        op                = iodr_pkg::OP_HOLD;
        delivered_next    = delivered_reg;
        count_next        = count_reg;
        item_seq_next     = item_seq_reg;
        item_payload_next = item_payload_reg;
        out_valid_next    = 1'b0;
        status_next       = status_reg;
        out_seq_next      = out_seq_reg;
        out_payload_next  = out_payload_reg;
        last_next         = last_reg;
        case (state_reg)
            iodr_pkg::S_IDLE:
            begin
                if (start)
                begin
                    item_seq_next     = msg_seq;
                    item_payload_next = msg_payload[iodr_pkg::PAYLOAD_BITS-1:0];
                end
            end
            iodr_pkg::S_EVAL:
            begin
                out_valid_next   = 1'b1;
                out_seq_next     = item_seq_reg;
                out_payload_next = '0;
                last_next        = 1'b1;
                if (stale)
                begin
                    status_next = iodr_pkg::ST_DUPLICATE;
                end
                else if (in_order)
                begin
                    status_next      = iodr_pkg::ST_DELIVERED;
                    out_payload_next = iodr_pkg::MSG_BITS'(item_payload_reg);
                    delivered_next   = item_seq_reg;
                    last_next        = !head_follows;
                end
                else if (sts.any_match)
                begin
                    status_next = iodr_pkg::ST_DUPLICATE;
                end
                else if (full)
                begin
                    status_next = iodr_pkg::ST_REFUSED;
                end
                else
                begin
                    status_next = iodr_pkg::ST_BUFFERED;
                    op          = iodr_pkg::OP_INSERT;
                    count_next  = count_reg + iodr_pkg::COUNT_BITS'(1);
                end
            end
            iodr_pkg::S_DRAIN:
            begin
                // deliver the head and advance the row by one cell
                out_valid_next   = 1'b1;
                status_next      = iodr_pkg::ST_DELIVERED;
                out_seq_next     = sts.head_seq;
                out_payload_next = iodr_pkg::MSG_BITS'(sts.head_payload);
                last_next        = !next_follows;
                delivered_next   = sts.head_seq;
                op               = iodr_pkg::OP_POP;
                count_next       = count_reg - iodr_pkg::COUNT_BITS'(1);
            end
            default:
            begin
                op = iodr_pkg::OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iodr_pkg::S_IDLE;
            null_reg      <= '0;
            delivered_reg <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            delivered_reg <= delivered_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                null_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_seq_reg     <= item_seq_next;
        item_payload_reg <= item_payload_next;
        status_reg       <= status_next;
        out_seq_reg      <= out_seq_next;
        out_payload_reg  <= out_payload_next;
        last_reg         <= last_next;
    end

    `IODR_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= iodr_pkg::COUNT_BITS'(iodr_pkg::HOLD_DEPTH), "fill count beyond store depth")
    `IODR_ASSERT_NOW(a_drain_nonempty, state_reg == iodr_pkg::S_DRAIN, count_reg != '0, "drain with empty store")
    `IODR_ASSERT_NEXT(a_run_continues, out_valid_reg && !last_reg, out_valid_reg, "result run broken before last")
    `IODR_ASSERT_NEXT(a_accept_eval, !busy && start, state_reg == iodr_pkg::S_EVAL, "accepted item not evaluated")

endmodule

`default_nettype wire
